FILE: design/deu_pkg.sv
// ----------------------------------------------------------------------------
// deu_pkg: shared constants for the equirectangular projection block
// Fixed-point widths, the arctangent table and configuration register codes.
// ----------------------------------------------------------------------------
package deu_pkg;

	localparam int ANGLE_STEPS_DEF = 16;
	localparam int ATAN_LEN        = 24;

	localparam int IN_W    = 16;
	localparam int SQ_W    = 32;
	localparam int RAD_W   = 48;
	localparam int ROOT_W  = 24;
	localparam int VEC_W   = 26;
	localparam int CW      = 44;
	localparam int AW      = 26;
	localparam int SIZE_W  = 13;
	localparam int PROD_W  = 40;
	localparam int RAW_W   = 26;
	localparam int COORD_W = 21;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd2048;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd1024;

	localparam logic signed [AW-1:0] HALF_TURN = 26'sd8388608;

	localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
		22'd166669,  22'd83416,   22'd41718,  22'd20860,
		22'd10430,   22'd5215,    22'd2608,   22'd1304,
		22'd652,     22'd326,     22'd163,    22'd81,
		22'd41,      22'd20,      22'd10,     22'd5,
		22'd3,       22'd1,       22'd1,      22'd0
	};

	localparam int SQRT_STAGES = 12;

	function automatic int deu_latency(input int steps);
		return steps + 19;
	endfunction

endpackage

FILE: design/deu_sqrt.sv
// ----------------------------------------------------------------------------
// deu_sqrt: pipelined integer square root
// Two result bits per stage, floor(sqrt) of a 48-bit radicand, with sideband.
// ----------------------------------------------------------------------------
module deu_sqrt import deu_pkg::*; #(
	parameter int SIDE_W = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_i,
	input  logic [RAD_W-1:0]  rad_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              valid_o,
	output logic [ROOT_W-1:0] root_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int REM_W = ROOT_W + 2;

	logic              v_s    [SQRT_STAGES+1];
	logic [RAD_W-1:0]  rad_s  [SQRT_STAGES+1];
	logic [REM_W-1:0]  rem_s  [SQRT_STAGES+1];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES+1];
	logic [SIDE_W-1:0] side_s [SQRT_STAGES+1];

	function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(
		input logic [REM_W-1:0]  rem,
		input logic [ROOT_W-1:0] root,
		input logic [1:0]        bits
	);
		logic [REM_W:0]   rem_n;
		logic [REM_W:0]   trial;
		logic [ROOT_W-1:0] root_n;
		rem_n = {rem[REM_W-2:0], bits};
		trial = {1'b0, root, 2'b01};
		if (rem_n >= trial) begin
			rem_n  = rem_n - trial;
			root_n = {root[ROOT_W-2:0], 1'b1};
		end else begin
			root_n = {root[ROOT_W-2:0], 1'b0};
		end
		return {rem_n[REM_W-1:0], root_n};
	endfunction

	assign v_s[0]    = valid_i;
	assign rad_s[0]  = rad_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_i;

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic [REM_W+ROOT_W-1:0] a;
		logic [REM_W+ROOT_W-1:0] b;
		always_comb begin
			a = sqrt_step(rem_s[g], root_s[g], rad_s[g][RAD_W-1 -: 2]);
			b = sqrt_step(a[REM_W+ROOT_W-1:ROOT_W], a[ROOT_W-1:0], rad_s[g][RAD_W-3 -: 2]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			rad_s[g+1]  <= {rad_s[g][RAD_W-5:0], 4'b0};
			rem_s[g+1]  <= b[REM_W+ROOT_W-1:ROOT_W];
			root_s[g+1] <= b[ROOT_W-1:0];
			side_s[g+1] <= side_s[g];
		end
	end

	assign valid_o = v_s[SQRT_STAGES];
	assign root_o  = root_s[SQRT_STAGES];
	assign side_o  = side_s[SQRT_STAGES];

endmodule

FILE: design/deu_cordic.sv
// ----------------------------------------------------------------------------
// deu_cordic: pipelined CORDIC vectoring for atan2
// One pre-rotation stage, then one micro-rotation per stage; angle in 2^-24 turn.
// ----------------------------------------------------------------------------
module deu_cordic import deu_pkg::*; #(
	parameter int STEPS = ANGLE_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_i,
	input  logic signed [VEC_W-1:0] s_i,
	input  logic signed [VEC_W-1:0] c_i,
	output logic                 valid_o,
	output logic signed [AW-1:0] ang_o,
	output logic                 zero_o
);

	logic                 v_s    [STEPS+1];
	logic signed [CW-1:0] s_s    [STEPS+1];
	logic signed [CW-1:0] c_s    [STEPS+1];
	logic signed [AW-1:0] ang_s  [STEPS+1];
	logic                 zero_s [STEPS+1];

	logic signed [CW-1:0] s_ext;
	logic signed [CW-1:0] c_ext;

	always_comb begin
		s_ext = {{(CW-VEC_W-16){s_i[VEC_W-1]}}, s_i, 16'b0};
		c_ext = {{(CW-VEC_W-16){c_i[VEC_W-1]}}, c_i, 16'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (s_i == '0) && (c_i == '0);
		if (c_i[VEC_W-1]) begin
			s_s[0]   <= -s_ext;
			c_s[0]   <= -c_ext;
			ang_s[0] <= s_i[VEC_W-1] ? -HALF_TURN : HALF_TURN;
		end else begin
			s_s[0]   <= s_ext;
			c_s[0]   <= c_ext;
			ang_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_iter
		logic signed [CW-1:0] ds;
		logic signed [CW-1:0] dc;
		logic signed [AW-1:0] t;
		logic                 pos;
		always_comb begin
			ds  = s_s[g] >>> g;
			dc  = c_s[g] >>> g;
			t   = $signed({{(AW-22){1'b0}}, ATAN_TAB[g]});
			pos = !s_s[g][CW-1] && (s_s[g] != '0);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			zero_s[g+1] <= zero_s[g];
			if (pos) begin
				c_s[g+1]   <= c_s[g] + ds;
				s_s[g+1]   <= s_s[g] - dc;
				ang_s[g+1] <= ang_s[g] + t;
			end else begin
				c_s[g+1]   <= c_s[g] - ds;
				s_s[g+1]   <= s_s[g] + dc;
				ang_s[g+1] <= ang_s[g] - t;
			end
		end
	end

	assign valid_o = v_s[STEPS];
	assign ang_o   = ang_s[STEPS];
	assign zero_o  = zero_s[STEPS];

endmodule

FILE: design/direction_to_equirect_uv.sv
// Throughput: one direction per cycle; busy stays low and start is taken every cycle.
// The pipeline is the 12-stage square root, then a CORDIC pre-rotation and one CORDIC stage per angle step.
// Reset clears all valid bits and loads width 2048 and height 1024.
// The receiver cannot stall; each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
// direction_to_equirect_uv: ray direction to panorama texture coordinates
// Computes yaw and pitch by CORDIC and scales them to u and v with a bounds flag.
// ----------------------------------------------------------------------------
module direction_to_equirect_uv import deu_pkg::*; #(
	parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [IN_W-1:0]      dir_x,
	input  logic signed [IN_W-1:0]      dir_y,
	input  logic signed [IN_W-1:0]      dir_z,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	output logic                        done,
	output logic [COORD_W-1:0]          u_coord,
	output logic [COORD_W-1:0]          v_coord,
	output logic                        inside_res
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	logic                   v_s1, v_s2, v_s3;
	logic signed [IN_W-1:0] x_s1, y_s1, z_s1;
	logic signed [IN_W-1:0] x_s2, y_s2, z_s2;
	logic signed [IN_W-1:0] x_s3, y_s3, z_s3;
	logic [SQ_W-1:0]        xx_s2, zz_s2;
	logic [RAD_W-1:0]       rad_s3;

	logic                   sq_valid;
	logic [ROOT_W-1:0]      root;
	logic [3*IN_W-1:0]      side;
	logic signed [IN_W-1:0] sx, sy, sz;

	logic signed [VEC_W-1:0] yaw_s_in, yaw_c_in, pit_s_in, pit_c_in;
	logic                    yaw_valid, pit_valid;
	logic signed [AW-1:0]    yaw_ang, pit_ang;
	logic                    yaw_zero, pit_zero;

	logic                     v_s4, v_s5;
	logic signed [PROD_W-1:0] pu_s4, pv_s4;
	logic signed [RAW_W-1:0]  ru_s5, rv_s5;

	logic signed [AW-1:0]     yaw_eff, pit_eff;
	logic signed [PROD_W-1:0] tu, tv;
	logic signed [RAW_W-1:0]  ru, rv;
	logic signed [RAW_W-1:0]  umax, vmax;
	logic signed [SIZE_W:0]   wm1, hm1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= dir_x;
		y_s1  <= dir_y;
		z_s1  <= dir_z;
		xx_s2 <= SQ_W'(x_s1 * x_s1);
		zz_s2 <= SQ_W'(z_s1 * z_s1);
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		z_s2  <= z_s1;
		rad_s3 <= {xx_s2 + zz_s2, 16'b0};
		x_s3  <= x_s2;
		y_s3  <= y_s2;
		z_s3  <= z_s2;
	end

	deu_sqrt #(.SIDE_W(3*IN_W)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (v_s3),
		.rad_i   (rad_s3),
		.side_i  ({x_s3, y_s3, z_s3}),
		.valid_o (sq_valid),
		.root_o  (root),
		.side_o  (side)
	);

	always_comb begin
		sx = side[3*IN_W-1:2*IN_W];
		sy = side[2*IN_W-1:IN_W];
		sz = side[IN_W-1:0];
		yaw_s_in = {{(VEC_W-IN_W-8){sx[IN_W-1]}}, sx, 8'b0};
		yaw_c_in = {{(VEC_W-IN_W-8){sz[IN_W-1]}}, sz, 8'b0};
		pit_s_in = {{(VEC_W-IN_W-8){sy[IN_W-1]}}, sy, 8'b0};
		pit_c_in = {{(VEC_W-ROOT_W){1'b0}}, root};
	end

	deu_cordic #(.STEPS(ANGLE_STEPS)) u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (sq_valid),
		.s_i     (yaw_s_in),
		.c_i     (yaw_c_in),
		.valid_o (yaw_valid),
		.ang_o   (yaw_ang),
		.zero_o  (yaw_zero)
	);

	deu_cordic #(.STEPS(ANGLE_STEPS)) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (sq_valid),
		.s_i     (pit_s_in),
		.c_i     (pit_c_in),
		.valid_o (pit_valid),
		.ang_o   (pit_ang),
		.zero_o  (pit_zero)
	);

	always_comb begin
		yaw_eff = yaw_zero ? '0 : yaw_ang;
		pit_eff = pit_zero ? '0 : pit_ang;
		tu = (pu_s4 + PROD_W'(32768)) >>> 16;
		tv = (pv_s4 + PROD_W'(32768)) >>> 16;
		ru = tu[RAW_W-1:0] + $signed({{(RAW_W-SIZE_W-7){1'b0}}, width_q, 7'b0});
		rv = tv[RAW_W-1:0] + $signed({{(RAW_W-SIZE_W-7){1'b0}}, height_q, 7'b0});
		wm1  = $signed({1'b0, width_q}) - 14'sd1;
		hm1  = $signed({1'b0, height_q}) - 14'sd1;
		umax = {{(RAW_W-SIZE_W-9){wm1[SIZE_W]}}, wm1, 8'b0};
		vmax = {{(RAW_W-SIZE_W-9){hm1[SIZE_W]}}, hm1, 8'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= yaw_valid && pit_valid;
			v_s5 <= v_s4;
			done <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		pu_s4 <= $signed({1'b0, width_q}) * yaw_eff;
		pv_s4 <= $signed({1'b0, height_q}) * pit_eff;
		ru_s5 <= ru;
		rv_s5 <= rv;
		inside_res <= !ru_s5[RAW_W-1] && (ru_s5 <= umax) &&
		              !rv_s5[RAW_W-1] && (rv_s5 <= vmax);
		if (ru_s5[RAW_W-1]) begin
			u_coord <= '0;
		end else if (ru_s5[RAW_W-2:COORD_W] != '0) begin
			u_coord <= '1;
		end else begin
			u_coord <= ru_s5[COORD_W-1:0];
		end
		if (rv_s5[RAW_W-1]) begin
			v_coord <= '0;
		end else if (rv_s5[RAW_W-2:COORD_W] != '0) begin
			v_coord <= '1;
		end else begin
			v_coord <= rv_s5[COORD_W-1:0];
		end
	end

endmodule

FILE: design/deu_checker.sv
// ----------------------------------------------------------------------------
// deu_checker: port-level checks for the equirectangular projection block
// Verifies fixed latency in both directions and that the block never stalls.
// ----------------------------------------------------------------------------
module deu_checker import deu_pkg::*; #(
	parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_ready,
	input logic done
);

	localparam int LAT = deu_latency(ANGLE_STEPS);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted beat");

endmodule

bind direction_to_equirect_uv deu_checker #(.ANGLE_STEPS(ANGLE_STEPS)) u_deu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_ready (cfg_ready),
	.done      (done)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for direction_to_equirect_uv
// Drives ray directions in directed rows and random phases, predicts u, v and
// the bounds flag with a local CORDIC model, and checks every done beat.
// ----------------------------------------------------------------------------
module testbench;
	import deu_pkg::*;

	localparam int LAT = ANGLE_STEPS_DEF + 19;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
		logic               ins;
	} uv_t;

	typedef struct {
		logic signed [IN_W-1:0] x, y, z;
		bit                     known;
		uv_t                    res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic signed [IN_W-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic cfg_valid = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic busy, cfg_ready, done, inside_res;
	logic [COORD_W-1:0] u_coord, v_coord;

	longint cycles = 0;
	int errors = 0;
	int idle_pct = 0;
	uv_t pending_uv[$];
	longint width_q = 2048, height_q = 1024;
	row_t rows[$];

	direction_to_equirect_uv dut (.*);

	always #5 clk = ~clk;

	function automatic longint shr(longint a, int n);
		return a >>> n;
	endfunction

	function automatic longint root64(longint n);
		longint r = 0, b = longint'(1) << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint turn_angle(longint s, longint c);
		longint a = 0, ds, dc;
		if (s == 0 && c == 0) return 0;
		s *= 65536;
		c *= 65536;
		if (c < 0) begin
			a = (s >= 0) ? 8388608 : -8388608;
			s = -s;
			c = -c;
		end
		for (int i = 0; i < ANGLE_STEPS_DEF && i < ATAN_LEN; i++) begin
			ds = shr(s, i);
			dc = shr(c, i);
			if (s > 0) begin
				c += ds; s -= dc; a += longint'(ATAN_TAB[i]);
			end else begin
				c -= ds; s += dc; a -= longint'(ATAN_TAB[i]);
			end
		end
		return a;
	endfunction

	function automatic longint clamp21(longint v);
		if (v < 0) return 0;
		if (v > 2097151) return 2097151;
		return v;
	endfunction

	function automatic uv_t project_uv(longint x, longint y, longint z);
		uv_t o;
		longint rad, yaw, pitch, u, v;
		rad = root64((x * x + z * z) << 16);
		yaw = turn_angle(x * 256, z * 256);
		pitch = turn_angle(y * 256, rad);
		u = width_q * 128 + shr(width_q * yaw + 32768, 16);
		v = height_q * 128 + shr(height_q * pitch + 32768, 16);
		o.u = COORD_W'(clamp21(u));
		o.v = COORD_W'(clamp21(v));
		o.ins = u >= 0 && u <= (width_q - 1) * 256 && v >= 0 && v <= (height_q - 1) * 256;
		return o;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("direction_to_equirect_uv test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		uv_t e;
		if (arst_n && done) begin
			if (pending_uv.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat u=%0d v=%0d", u_coord, v_coord);
			end else begin
				e = pending_uv.pop_front();
				if (e.u !== u_coord || e.v !== v_coord || e.ins !== inside_res) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp u=%0d v=%0d in=%0d got u=%0d v=%0d in=%0d",
							e.u, e.v, e.ins, u_coord, v_coord, inside_res);
				end
			end
		end
	end

	task automatic send_dir(logic signed [IN_W-1:0] x, y, z, bit known, uv_t res);
		uv_t p;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1; dir_x <= x; dir_y <= y; dir_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = project_uv(x, y, z);
		if (known && res != p) begin
			errors++;
			if (errors <= 10) $display("table row disagrees with prediction");
		end
		pending_uv.push_back(p);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_IMAGE_WIDTH) width_q = val & 16'h1FFF;
		else if (idx == REG_IMAGE_HEIGHT) height_q = val & 16'h1FFF;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (pending_uv.size() != 0) @(negedge clk);
		repeat (LAT + 5) @(negedge clk);
	endtask

	task automatic add_row(int x, y, z, bit k = 0, int u = 0, int v = 0, bit ins = 0);
		row_t r;
		r.x = IN_W'(x); r.y = IN_W'(y); r.z = IN_W'(z); r.known = k;
		r.res.u = COORD_W'(u); r.res.v = COORD_W'(v); r.res.ins = ins;
		rows.push_back(r);
	endtask

	task automatic random_phase(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(9);
			if (k == 0)
				send_dir(IN_W'($urandom_range(3) - 1), IN_W'($urandom_range(3) - 1),
					IN_W'($urandom_range(3) - 1), 0, '0);
			else if (k == 1)
				send_dir(IN_W'(16'h8000 + $urandom_range(1)), IN_W'($urandom), '0, 0, '0);
			else
				send_dir(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom), 0, '0);
		end
	endtask

	initial begin
		int ws [5] = '{1, 4096, 8191, 333, 0};
		int hs [5] = '{4096, 1, 8191, 777, 0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		add_row(0, 0, 0, 1, 2048 * 128, 1024 * 128, 1);
		add_row(0, 0, 16384);
		add_row(0, 0, -16384);
		add_row(16384, 0, 0);
		add_row(-16384, 0, 0);
		add_row(0, 16384, 0);
		add_row(0, -16384, 0);
		add_row(32767, 32767, 32767);
		add_row(-32768, -32768, -32768);
		add_row(-32768, 32767, -32768);
		add_row(32767, -32768, 0);
		add_row(0, 0, -1);
		add_row(-1, 0, -32768);
		add_row(1, 1, 1);
		add_row(-1, -1, -1);
		add_row(16'h5555, 16'h2AAA, 16'h5555);
		add_row(16'h2AAA, 16'h5555, 16'h2AAA);
		foreach (rows[i]) send_dir(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 5) begin
				write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(ws[ph] | ($urandom_range(1) << 13)));
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hs[ph] | ($urandom_range(7) << 13)));
			end else begin
				write_reg($urandom_range(1) ? 2'd2 : 2'd3, CFG_DATA_W'($urandom));
				write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 4096)));
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 4096)));
			end
			cfg_valid <= 0;
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 67;
				2: idle_pct = 67;
				default: idle_pct = 19;
			endcase
			random_phase(100);
			drain();
		end

		if (errors == 0) begin
			$display("direction_to_equirect_uv test passed");
		end else begin
			$display("direction_to_equirect_uv test failed");
		end
		$finish;
	end
endmodule

FILE: filelist.f
design/deu_pkg.sv
design/deu_sqrt.sv
design/deu_cordic.sv
design/direction_to_equirect_uv.sv
design/deu_checker.sv
tb/testbench.sv
